>>> sv/x86se_pkg.sv
`timescale 1ns / 1ps
package x86se_pkg;

  localparam logic [3:0] CMD_SUB       = 4'd0;
  localparam logic [3:0] CMD_MOV       = 4'd1;
  localparam logic [3:0] CMD_CALL      = 4'd2;
  localparam logic [3:0] CMD_RET       = 4'd3;
  localparam logic [3:0] CMD_PUSH      = 4'd4;
  localparam logic [3:0] CMD_POP       = 4'd5;
  localparam logic [3:0] CMD_OTHER     = 4'd6;
  localparam logic [3:0] CMD_LOAD_GPR  = 4'd7;
  localparam logic [3:0] CMD_LOAD_RIP  = 4'd8;
  localparam logic [3:0] CMD_LOAD_FLAGS = 4'd9;

  localparam logic [2:0] PART_LO    = 3'd0;
  localparam logic [2:0] PART_HI    = 3'd1;
  localparam logic [2:0] PART_WORD  = 3'd2;
  localparam logic [2:0] PART_DWORD = 3'd3;
  localparam logic [2:0] PART_QWORD = 3'd4;

  localparam logic [3:0] RSP_INDEX = 4'd4;
  localparam logic [63:0] STACK_SLOT = 64'd8;

  localparam int FLAG_CF = 0;
  localparam int FLAG_PF = 2;
  localparam int FLAG_ZF = 6;
  localparam int FLAG_SF = 7;

  typedef struct packed {
    logic [3:0]         cmd;
    logic               dst_is_reg;
    logic [3:0]         dst_reg;
    logic [2:0]         dst_part;
    logic               src_is_reg;
    logic [3:0]         src_reg;
    logic [2:0]         src_part;
    logic signed [63:0] imm;
    logic [3:0]         length;
    logic [63:0]        stack_word;
  } x86se_in_t;

  typedef struct packed {
    logic        write_valid;
    logic [63:0] write_addr;
    logic [63:0] write_data;
    logic [63:0] rip_out;
    logic [11:0] flags_out;
    logic [63:0] dest_value;
  } x86se_out_t;

  function automatic logic [63:0] part_mask(input logic [2:0] part);
    case (part)
      PART_LO, PART_HI: part_mask = 64'h0000_0000_0000_00FF;
      PART_WORD:        part_mask = 64'h0000_0000_0000_FFFF;
      PART_DWORD:       part_mask = 64'h0000_0000_FFFF_FFFF;
      default:          part_mask = '1;
    endcase
  endfunction

  function automatic logic [63:0] part_read(input logic [63:0] full, input logic [2:0] part);
    if (part == PART_HI) begin
      part_read = (full >> 8) & part_mask(part);
    end else begin
      part_read = full & part_mask(part);
    end
  endfunction

  function automatic logic [63:0] part_merge(input logic [63:0] full, input logic [2:0] part,
                                             input logic [63:0] value);
    logic [63:0] m;
    m = part_mask(part);
    if (part == PART_HI) begin
      part_merge = (full & ~(m << 8)) | ((value & m) << 8);
    end else begin
      part_merge = (full & ~m) | (value & m);
    end
  endfunction

  function automatic logic part_msb(input logic [63:0] value, input logic [2:0] part);
    case (part)
      PART_LO, PART_HI: part_msb = value[7];
      PART_WORD:        part_msb = value[15];
      PART_DWORD:       part_msb = value[31];
      default:          part_msb = value[63];
    endcase
  endfunction

endpackage

>>> sv/x86_subset_execute_unit.sv
`timescale 1ns / 1ps
// Channel  | valid      | stall      | payload
// command  | cmd_valid  | cmd_stall  | cmd_item (x86se_in_t)
// result   | res_valid  | res_stall  | res_item (x86se_out_t)
//
// One instruction per cycle unless the result stalls. A transaction is registered with
// its two register-file reads, executes from that stage and lands in the result register.
// The register file is a two-read, one-write array; rsp lives in its own register.
// Reset clears rip, flags, rsp and the file's entry valid bits (invalid entries read zero).
// A stalled result holds the execute stage; cmd_stall rises only when that stage is full.
module x86_subset_execute_unit
  import x86se_pkg::*;
#(
  parameter int REG_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  x86se_in_t  cmd_item,
  output logic       res_valid,
  input  logic       res_stall,
  output x86se_out_t res_item
);

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [63:0]          regs [REG_COUNT];
  logic [REG_COUNT-1:0] reg_ok;
  logic [63:0]          rsp;
  logic [63:0]          rip;
  logic [11:0]          flags;

  logic        s1_valid;
  x86se_in_t   s1;
  logic [63:0] dst_q;
  logic [63:0] src_q;
  logic        dst_fwd;
  logic        src_fwd;
  logic        dst_hit;
  logic        src_hit;
  logic [63:0] fwd_data;

  logic        cmd_take;
  logic        exec;
  logic        in_dst_range;
  logic        in_src_range;
  logic        s1_dst_range;

  logic [63:0] dfull;
  logic [63:0] sfull;
  logic [63:0] srcv;
  logic [63:0] imm_u;
  logic [63:0] next_rip;
  logic [63:0] rsp_stk;
  logic [63:0] a_val;
  logic [63:0] b_val;
  logic [63:0] diff;
  logic        dst_we;
  logic [63:0] dst_wval;
  logic        mem_we;
  logic [63:0] rsp_next;
  logic [63:0] rip_next;
  logic [11:0] flags_next;
  x86se_out_t  res_next;

  assign exec      = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && !exec;
  assign cmd_take  = cmd_valid && !cmd_stall;

  assign in_dst_range = {1'b0, cmd_item.dst_reg} < 5'(REG_COUNT);
  assign in_src_range = {1'b0, cmd_item.src_reg} < 5'(REG_COUNT);
  assign s1_dst_range = {1'b0, s1.dst_reg} < 5'(REG_COUNT);

  always_comb begin
    imm_u    = $unsigned(s1.imm);
    next_rip = rip + 64'(s1.length);

    if (s1.dst_reg == RSP_INDEX) begin
      dfull = rsp;
    end else if (dst_fwd) begin
      dfull = fwd_data;
    end else if (dst_hit) begin
      dfull = dst_q;
    end else begin
      dfull = '0;
    end

    if (s1.src_reg == RSP_INDEX) begin
      sfull = rsp;
    end else if (src_fwd) begin
      sfull = fwd_data;
    end else if (src_hit) begin
      sfull = src_q;
    end else begin
      sfull = '0;
    end

    srcv = part_read(sfull, s1.src_part);

    case (s1.cmd)
      CMD_CALL, CMD_PUSH: rsp_stk = rsp - STACK_SLOT;
      CMD_RET, CMD_POP:   rsp_stk = rsp + STACK_SLOT;
      default:            rsp_stk = rsp;
    endcase
    if (s1.dst_reg == RSP_INDEX) begin
      dfull = rsp_stk;
    end

    a_val = part_read(dfull, s1.dst_part);
    b_val = (s1.src_is_reg ? srcv : imm_u) & part_mask(s1.dst_part);
    diff  = (a_val - b_val) & part_mask(s1.dst_part);

    dst_we     = 1'b0;
    dst_wval   = dfull;
    rip_next   = next_rip;
    flags_next = flags;
    res_next   = '0;

    case (s1.cmd)
      CMD_SUB: begin
        if (s1.dst_is_reg) begin
          dst_we              = 1'b1;
          dst_wval            = part_merge(dfull, s1.dst_part, diff);
          flags_next[FLAG_CF] = b_val > a_val;
          flags_next[FLAG_ZF] = diff == '0;
          flags_next[FLAG_SF] = part_msb(diff, s1.dst_part);
          flags_next[FLAG_PF] = ~^diff[7:0];
        end
      end
      CMD_MOV: begin
        if (s1.dst_is_reg) begin
          dst_we   = 1'b1;
          dst_wval = part_merge(dfull, s1.dst_part, s1.src_is_reg ? srcv : imm_u);
        end
      end
      CMD_CALL: begin
        res_next.write_valid = 1'b1;
        res_next.write_addr  = rsp_stk;
        res_next.write_data  = next_rip;
        rip_next             = s1.src_is_reg ? srcv : next_rip + imm_u;
      end
      CMD_RET: begin
        rip_next = s1.stack_word;
      end
      CMD_PUSH: begin
        res_next.write_valid = 1'b1;
        res_next.write_addr  = rsp_stk;
        res_next.write_data  = s1.src_is_reg ? srcv : imm_u;
      end
      CMD_POP: begin
        if (s1.dst_is_reg) begin
          dst_we   = 1'b1;
          dst_wval = part_merge(dfull, s1.dst_part, s1.stack_word);
        end
      end
      CMD_LOAD_GPR: begin
        dst_we   = 1'b1;
        dst_wval = imm_u;
        rip_next = rip;
      end
      CMD_LOAD_RIP: begin
        rip_next = imm_u;
      end
      CMD_LOAD_FLAGS: begin
        flags_next = imm_u[11:0];
        rip_next   = rip;
      end
      default: begin
      end
    endcase

    rsp_next = (dst_we && s1.dst_reg == RSP_INDEX) ? dst_wval : rsp_stk;
    mem_we   = exec && dst_we && s1_dst_range && s1.dst_reg != RSP_INDEX;

    res_next.rip_out   = rip_next;
    res_next.flags_out = flags_next;
    if (s1.dst_reg == RSP_INDEX) begin
      res_next.dest_value = rsp_next;
    end else if (!s1_dst_range) begin
      res_next.dest_value = '0;
    end else if (dst_we) begin
      res_next.dest_value = dst_wval;
    end else begin
      res_next.dest_value = dfull;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      regs[s1.dst_reg[IDX_W-1:0]] <= dst_wval;
    end
    if (cmd_take) begin
      dst_q <= regs[cmd_item.dst_reg[IDX_W-1:0]];
      src_q <= regs[cmd_item.src_reg[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1       <= cmd_item;
      fwd_data <= dst_wval;
    end
    if (exec) begin
      res_item <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      reg_ok    <= '0;
      rsp       <= '0;
      rip       <= '0;
      flags     <= '0;
      dst_fwd   <= 1'b0;
      src_fwd   <= 1'b0;
      dst_hit   <= 1'b0;
      src_hit   <= 1'b0;
    end else begin
      if (cmd_take) begin
        s1_valid <= 1'b1;
        dst_fwd  <= mem_we && cmd_item.dst_reg == s1.dst_reg;
        src_fwd  <= mem_we && cmd_item.src_reg == s1.dst_reg;
        dst_hit  <= in_dst_range && reg_ok[cmd_item.dst_reg[IDX_W-1:0]];
        src_hit  <= in_src_range && reg_ok[cmd_item.src_reg[IDX_W-1:0]];
      end else if (exec) begin
        s1_valid <= 1'b0;
      end
      if (exec) begin
        res_valid <= 1'b1;
        rsp       <= rsp_next;
        rip       <= rip_next;
        flags     <= flags_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (mem_we) begin
        reg_ok[s1.dst_reg[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> s1_valid && res_valid && res_stall)
    else $error("command stalled with a free execute stage");

  a_exec_yields_result: assert property (@(posedge clk) disable iff (rst)
    exec |=> res_valid)
    else $error("executed transaction produced no result");

  a_stack_write_addr: assert property (@(posedge clk) disable iff (rst)
    exec && (s1.cmd == CMD_CALL || s1.cmd == CMD_PUSH)
    |=> res_item.write_valid && res_item.write_addr == rsp)
    else $error("stack write address differs from new rsp");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench
  import x86se_pkg::*;
();

  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
  localparam logic [2:0] PART_RSVD5    = 3'd5;
  localparam logic [2:0] PART_RSVD7    = 3'd7;
  localparam int         HOLD_CYCLES   = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  x86se_in_t  cmd_item = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  x86se_out_t res_item;

  x86_subset_execute_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // architectural state tracked by the testbench
  logic [63:0] arch_gpr [16];
  logic [63:0] arch_rip = '0;
  logic [63:0] arch_flags = '0;

  x86se_out_t retire_q [$];
  int n_fail = 0;
  int n_res = 0;
  bit gaps_on = 1'b0;
  bit stall_on = 1'b0;
  bit hold_req = 1'b0;

  typedef struct packed {
    x86se_in_t  insn;
    logic       typed;
    x86se_out_t want;
  } dir_row_t;

  dir_row_t dir_tab [$];

  initial begin
    for (int i = 0; i < 16; i++) arch_gpr[i] = '0;
  end

  function automatic logic [63:0] field_mask(input logic [2:0] p);
    case (p)
      PART_LO, PART_HI: return 64'hFF;
      PART_WORD:        return 64'hFFFF;
      PART_DWORD:       return 64'hFFFF_FFFF;
      default:          return '1;
    endcase
  endfunction

  function automatic int field_lsb(input logic [2:0] p);
    return (p == PART_HI) ? 8 : 0;
  endfunction

  function automatic int field_bits(input logic [2:0] p);
    case (p)
      PART_LO, PART_HI: return 8;
      PART_WORD:        return 16;
      PART_DWORD:       return 32;
      default:          return 64;
    endcase
  endfunction

  function automatic logic [63:0] reg_field(input logic [3:0] idx, input logic [2:0] p);
    return (arch_gpr[idx] >> field_lsb(p)) & field_mask(p);
  endfunction

  function automatic logic [63:0] merge_field(input logic [63:0] full, input logic [2:0] p,
                                              input logic [63:0] val);
    logic [63:0] m;
    m = field_mask(p) << field_lsb(p);
    return (full & ~m) | ((val << field_lsb(p)) & m);
  endfunction

  // executes one instruction against the tracked state
  function automatic x86se_out_t retire_insn(input x86se_in_t it);
    x86se_out_t o;
    logic [63:0] m, a, b, r, next, src;
    bit advance;
    o = '0;
    advance = 1'b1;
    next = arch_rip + 64'(it.length);
    src = it.src_is_reg ? reg_field(it.src_reg, it.src_part) : it.imm;
    case (it.cmd)
      CMD_SUB: begin
        if (it.dst_is_reg) begin
          m = field_mask(it.dst_part);
          a = reg_field(it.dst_reg, it.dst_part);
          b = src & m;
          r = (a - b) & m;
          arch_gpr[it.dst_reg] = merge_field(arch_gpr[it.dst_reg], it.dst_part, r);
          arch_flags[FLAG_CF] = b > a;
          arch_flags[FLAG_ZF] = r == '0;
          arch_flags[FLAG_SF] = r[field_bits(it.dst_part) - 1];
          arch_flags[FLAG_PF] = ~^r[7:0];
        end
      end
      CMD_MOV: begin
        if (it.dst_is_reg) begin
          arch_gpr[it.dst_reg] = merge_field(arch_gpr[it.dst_reg], it.dst_part, src);
        end
      end
      CMD_CALL: begin
        arch_gpr[RSP_INDEX] = arch_gpr[RSP_INDEX] - STACK_SLOT;
        o.write_valid = 1'b1;
        o.write_addr = arch_gpr[RSP_INDEX];
        o.write_data = next;
        arch_rip = it.src_is_reg ? src : next + it.imm;
        advance = 1'b0;
      end
      CMD_RET: begin
        arch_gpr[RSP_INDEX] = arch_gpr[RSP_INDEX] + STACK_SLOT;
        arch_rip = it.stack_word;
        advance = 1'b0;
      end
      CMD_PUSH: begin
        arch_gpr[RSP_INDEX] = arch_gpr[RSP_INDEX] - STACK_SLOT;
        o.write_valid = 1'b1;
        o.write_addr = arch_gpr[RSP_INDEX];
        o.write_data = src;
      end
      CMD_POP: begin
        arch_gpr[RSP_INDEX] = arch_gpr[RSP_INDEX] + STACK_SLOT;
        if (it.dst_is_reg) begin
          arch_gpr[it.dst_reg] = merge_field(arch_gpr[it.dst_reg], it.dst_part, it.stack_word);
        end
      end
      CMD_LOAD_GPR: begin
        arch_gpr[it.dst_reg] = it.imm;
        advance = 1'b0;
      end
      CMD_LOAD_RIP: begin
        arch_rip = it.imm;
        advance = 1'b0;
      end
      CMD_LOAD_FLAGS: begin
        arch_flags = it.imm;
        advance = 1'b0;
      end
      default: ;
    endcase
    if (advance) arch_rip = next;
    o.rip_out = arch_rip;
    o.flags_out = arch_flags[11:0];
    o.dest_value = arch_gpr[it.dst_reg];
    return o;
  endfunction

  function automatic x86se_in_t insn(input logic [3:0] c, input logic dri, input logic [3:0] dr,
                                     input logic [2:0] dp, input logic sri, input logic [3:0] sr,
                                     input logic [2:0] sp, input logic [63:0] imm,
                                     input logic [3:0] len, input logic [63:0] word);
    x86se_in_t i;
    i.cmd = c;
    i.dst_is_reg = dri;
    i.dst_reg = dr;
    i.dst_part = dp;
    i.src_is_reg = sri;
    i.src_reg = sr;
    i.src_part = sp;
    i.imm = imm;
    i.length = len;
    i.stack_word = word;
    return i;
  endfunction

  function automatic x86se_out_t want(input logic wv, input logic [63:0] wa,
                                     input logic [63:0] wd, input logic [63:0] rip,
                                     input logic [11:0] fl, input logic [63:0] dv);
    x86se_out_t o;
    o.write_valid = wv;
    o.write_addr = wa;
    o.write_data = wd;
    o.rip_out = rip;
    o.flags_out = fl;
    o.dest_value = dv;
    return o;
  endfunction

  task automatic add_row(input x86se_in_t i, input logic t, input x86se_out_t w);
    dir_row_t r;
    r.insn = i;
    r.typed = t;
    r.want = w;
    dir_tab.insert(dir_tab.size(), r);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b1, 63'd0};
      3: return {1'b0, {63{1'b1}}};
      4: return 64'($urandom_range(0, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [3:0] rand_reg();
    return ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 4)) : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [2:0] rand_part();
    return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
  endfunction

  function automatic x86se_in_t rand_insn();
    x86se_in_t i;
    i.cmd = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    i.dst_is_reg = $urandom_range(0, 9) != 0;
    i.dst_reg = rand_reg();
    i.dst_part = rand_part();
    i.src_is_reg = 1'($urandom_range(0, 1));
    i.src_reg = rand_reg();
    i.src_part = rand_part();
    i.imm = rand_word();
    i.length = 4'($urandom_range(1, 15));
    i.stack_word = rand_word();
    return i;
  endfunction

  task automatic send_insn(input x86se_in_t it, input logic t, input x86se_out_t w);
    x86se_out_t p;
    cmd_item <= it;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    p = retire_insn(it);
    retire_q.insert(retire_q.size(), t ? w : p);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    n_fail++;
    if (n_fail <= 10) begin
      $display("result %0d %s mismatch: expected %h, got %h", n_res, what, exp_v, got_v);
    end
  endtask

  task automatic check_result(input x86se_out_t e, input x86se_out_t g);
    if (g.write_valid !== e.write_valid)
      flag_mismatch("write_valid", 64'(e.write_valid), 64'(g.write_valid));
    if (g.write_addr !== e.write_addr) flag_mismatch("write_addr", e.write_addr, g.write_addr);
    if (g.write_data !== e.write_data) flag_mismatch("write_data", e.write_data, g.write_data);
    if (g.rip_out !== e.rip_out) flag_mismatch("rip_out", e.rip_out, g.rip_out);
    if (g.flags_out !== e.flags_out)
      flag_mismatch("flags_out", 64'(e.flags_out), 64'(g.flags_out));
    if (g.dest_value !== e.dest_value) flag_mismatch("dest_value", e.dest_value, g.dest_value);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (retire_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("result %0d arrived with no transaction pending", n_res);
      end else begin
        check_result(retire_q.pop_front(), res_item);
      end
      n_res++;
    end
  end

  // result-side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int seg;
    add_row(insn(CMD_OTHER, 1, 0, PART_QWORD, 0, 0, PART_QWORD, '0, 15, '0), 1,
            want(0, '0, '0, 64'd15, '0, '0));
    add_row(insn(CMD_LOAD_RIP, 1, 0, PART_QWORD, 0, 0, PART_QWORD, '1, 15, '0), 1,
            want(0, '0, '0, '1, '0, '0));
    add_row(insn(CMD_OTHER, 1, 0, PART_QWORD, 0, 0, PART_QWORD, '0, 1, '0), 1,
            want(0, '0, '0, '0, '0, '0));
    add_row(insn(CMD_LOAD_FLAGS, 1, 0, PART_QWORD, 0, 0, PART_QWORD, '1, 15, '0), 1,
            want(0, '0, '0, '0, 12'hFFF, '0));
    add_row(insn(CMD_SUB, 1, 0, PART_LO, 0, 0, PART_LO, '0, 2, '0), 1,
            want(0, '0, '0, 64'd2, 12'hF7E, '0));
    add_row(insn(CMD_SUB, 1, 0, PART_LO, 0, 0, PART_LO, 64'd1, 3, '0), 0, '0);
    add_row(insn(CMD_LOAD_GPR, 0, RSP_INDEX, PART_HI, 0, 0, PART_LO, 64'h1000, 4, '0), 0, '0);
    add_row(insn(CMD_LOAD_GPR, 1, 1, PART_QWORD, 0, 0, PART_LO, {1'b1, 63'd0}, 4, '0), 0, '0);
    add_row(insn(CMD_LOAD_GPR, 1, 2, PART_QWORD, 0, 0, PART_LO, {1'b0, {63{1'b1}}}, 4, '0),
            0, '0);
    add_row(insn(CMD_MOV, 1, 3, PART_HI, 1, 2, PART_LO, '0, 3, '0), 0, '0);
    add_row(insn(CMD_SUB, 1, 2, PART_WORD, 1, 1, PART_HI, '0, 4, '0), 0, '0);
    add_row(insn(CMD_SUB, 1, 1, PART_DWORD, 0, 0, PART_LO, '1, 6, '0), 0, '0);
    add_row(insn(CMD_SUB, 1, 2, PART_QWORD, 1, 1, PART_QWORD, '0, 3, '0), 0, '0);
    add_row(insn(CMD_SUB, 1, 5, PART_RSVD7, 0, 0, PART_LO, 64'd5, 7, '0), 0, '0);
    add_row(insn(CMD_MOV, 1, 6, PART_RSVD5, 1, 1, PART_RSVD7, '0, 3, '0), 0, '0);
    add_row(insn(CMD_PUSH, 1, 0, PART_QWORD, 0, 0, PART_LO, '1, 2, '0), 0, '0);
    add_row(insn(CMD_PUSH, 1, 0, PART_QWORD, 1, RSP_INDEX, PART_QWORD, '0, 1, '0), 0, '0);
    add_row(insn(CMD_CALL, 1, 0, PART_QWORD, 0, 0, PART_LO, -64'sd16, 5, '0), 0, '0);
    add_row(insn(CMD_CALL, 1, 0, PART_QWORD, 1, 2, PART_DWORD, '0, 2, '0), 0, '0);
    add_row(insn(CMD_RET, 1, RSP_INDEX, PART_QWORD, 0, 0, PART_LO, '0, 1,
                 64'h0123_4567_89AB_CDEF), 0, '0);
    add_row(insn(CMD_POP, 1, RSP_INDEX, PART_QWORD, 0, 0, PART_LO, '0, 1, '1), 0, '0);
    add_row(insn(CMD_POP, 0, 7, PART_QWORD, 0, 0, PART_LO, '0, 1, 64'h55), 0, '0);
    add_row(insn(CMD_SUB, 0, 2, PART_QWORD, 0, 0, PART_LO, 64'd9, 3, '0), 0, '0);
    add_row(insn(CMD_MOV, 0, 2, PART_QWORD, 0, 0, PART_LO, 64'd9, 3, '0), 0, '0);
    add_row(insn(CMD_UNUSED_LO, 1, 15, PART_QWORD, 1, 15, PART_QWORD, '1, 15, '1), 0, '0);
    add_row(insn(CMD_UNUSED_HI, 1, 8, PART_QWORD, 1, 9, PART_QWORD, '1, 8, '1), 0, '0);
    add_row(insn(CMD_LOAD_FLAGS, 1, 0, PART_QWORD, 0, 0, PART_LO, '0, 1, '0), 0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[k]) send_insn(dir_tab[k].insn, dir_tab[k].typed, dir_tab[k].want);

    for (seg = 0; seg < 17; seg++) begin
      gaps_on = (seg < 14) && ($urandom_range(0, 2) != 0);
      stall_on = (seg < 14) && ($urandom_range(0, 2) != 0);
      if (seg == 4) begin
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      repeat (100) send_insn(rand_insn(), 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    while (retire_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_fail == 0 && retire_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
